FILE: hdl/cdgs_pkg.sv
// ----------------------------------------------------------------------------
// cdgs_pkg
// Shared types, constants and helpers of the gauge smoother.
// ----------------------------------------------------------------------------
package cdgs_pkg;

  localparam int VALUE_FRAC_BITS = 16;
  localparam int LEVEL_W         = VALUE_FRAC_BITS + 1;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << VALUE_FRAC_BITS;

  localparam int RAW_W   = 24;
  localparam int TIME_W  = 24;
  localparam int FS_W    = 23;

  localparam logic [TIME_W-1:0] MIN_SMOOTH = TIME_W'(7);
  localparam logic [31:0]       C048       = 32'd31457;
  localparam logic [31:0]       C0235      = 32'd15401;

  localparam int DIV_STEPS = 64;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int DSR_W     = 40;
  localparam int MUL_STEPS = 32;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);

  localparam logic [2:0] ADDR_FULL_SCALE  = 3'd0;
  localparam logic [2:0] ADDR_SMOOTH_TIME = 3'd4;

  localparam logic FUNC_VALUE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef enum logic [3:0] {
    STEP_GAUGE = 4'd0,
    STEP_XQ    = 4'd1,
    STEP_OMEGA = 4'd2,
    STEP_X2    = 4'd3,
    STEP_X3    = 4'd4,
    STEP_DEN1  = 4'd5,
    STEP_DEN2  = 4'd6,
    STEP_DECAY = 4'd7,
    STEP_OC    = 4'd8,
    STEP_TEMP  = 4'd9,
    STEP_OT    = 4'd10,
    STEP_NV    = 4'd11,
    STEP_OUT   = 4'd12
  } step_t;

  typedef struct packed {
    logic  load;
    logic  start;
    logic  snap;
    logic  publish;
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic func;
    logic dt_zero;
    logic st_zero;
  } status_t;

  function automatic logic is_div_step(input step_t s);
    return (s == STEP_GAUGE) || (s == STEP_XQ) || (s == STEP_OMEGA) || (s == STEP_DECAY);
  endfunction

  // signed divide by 2^k, truncating toward zero
  function automatic logic signed [63:0] sdiv_pow2(input logic signed [63:0] v,
                                                   input logic [4:0] k);
    logic signed [63:0] bias;
    bias = v[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (v + bias) >>> k;
  endfunction

endpackage

FILE: hdl/cdgs_div.sv
// ----------------------------------------------------------------------------
// cdgs_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cdgs_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [63:0]                 dividend,
  input  logic [cdgs_pkg::DSR_W-1:0]  divisor,
  output logic                        done,
  output logic [63:0]                 quotient
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [cdgs_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [cdgs_pkg::DSR_W-1:0]        rem_r, rem_nxt;
  logic [cdgs_pkg::DSR_W-1:0]        dsr_r, dsr_nxt;
  logic [63:0]                       quo_r, quo_nxt;
  logic [cdgs_pkg::DSR_W:0]          shifted;
  logic [cdgs_pkg::DSR_W:0]          diff;
  logic                              ge;

  assign shifted = {rem_r, quo_r[63]};
  assign diff    = shifted - {1'b0, dsr_r};
  assign ge      = shifted >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[cdgs_pkg::DSR_W-1:0] : shifted[cdgs_pkg::DSR_W-1:0];
      quo_nxt = {quo_r[62:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == cdgs_pkg::DIV_CNT_W'(cdgs_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hdl/cdgs_mul.sv
// ----------------------------------------------------------------------------
// cdgs_mul
// Shift-add multiplier: signed 64-bit times unsigned 32-bit, low 64 bits.
// ----------------------------------------------------------------------------
module cdgs_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [63:0] product
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [cdgs_pkg::MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [63:0]                    a_r, a_nxt;
  logic [31:0]                    b_r, b_nxt;
  logic [63:0]                    acc_r, acc_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_nxt = acc_r + a_r;
      end
      a_nxt   = {a_r[62:0], 1'b0};
      b_nxt   = {1'b0, b_r[31:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == cdgs_pkg::MUL_CNT_W'(cdgs_pkg::MUL_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

FILE: hdl/cdgs_dp.sv
// ----------------------------------------------------------------------------
// cdgs_dp
// Datapath: request and level registers, spring terms, shared divider and
// multiplier.
// ----------------------------------------------------------------------------
module cdgs_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cdgs_pkg::cmd_t                      cmd,
  output cdgs_pkg::status_t                   sts,
  input  logic                                in_func,
  input  logic [cdgs_pkg::RAW_W-1:0]          in_raw,
  input  logic [cdgs_pkg::TIME_W-1:0]         in_dt,
  input  logic [cdgs_pkg::FS_W-1:0]           full_scale,
  input  logic [cdgs_pkg::TIME_W-1:0]         smooth_time,
  output logic [cdgs_pkg::LEVEL_W-1:0]        gauge_value,
  output logic [cdgs_pkg::LEVEL_W-1:0]        lagging_value
);

  localparam int LW = cdgs_pkg::LEVEL_W;
  localparam int TW = cdgs_pkg::TIME_W;
  localparam logic signed [63:0] ONE64 = 64'sd1 <<< cdgs_pkg::VALUE_FRAC_BITS;

  logic                   func_r;
  logic [cdgs_pkg::RAW_W-1:0] raw_r;
  logic [TW-1:0]          dt_r;
  logic [LW-1:0]          now_r, now_nxt;
  logic [LW-1:0]          late_r, late_nxt;
  logic signed [31:0]     vel_r, vel_nxt;
  logic [24:0]            xq_r, xq_nxt;
  logic [30:0]            omega_r, omega_nxt;
  logic [32:0]            x2_r, x2_nxt;
  logic [40:0]            x3_r, x3_nxt;
  logic [39:0]            den_r, den_nxt;
  logic [20:0]            decay_r, decay_nxt;
  logic signed [63:0]     sum_r, sum_nxt;
  logic signed [63:0]     temp_r, temp_nxt;
  logic signed [63:0]     ot_r, ot_nxt;
  logic signed [63:0]     nv_r, nv_nxt;
  logic [LW-1:0]          gauge_o_r, lag_o_r;

  logic [TW-1:0]          st_e;
  logic [30:0]            lim;
  logic [TW-1:0]          dt_e;
  logic [cdgs_pkg::FS_W-1:0] fs_e;
  logic signed [63:0]     maxc, diff, chg, tc, vel_ext;
  logic signed [63:0]     p_s, out_v, nv_f;
  logic [63:0]            p_sh;
  logic                   up, over;

  logic                   div_start, div_done, mul_start, mul_done;
  logic [63:0]            dvd, quo, mul_a, prod;
  logic [cdgs_pkg::DSR_W-1:0] dsr;
  logic [31:0]            mul_b;

  assign st_e  = (smooth_time < cdgs_pkg::MIN_SMOOTH) ? cdgs_pkg::MIN_SMOOTH : smooth_time;
  assign lim   = {st_e, 7'd0};
  assign dt_e  = ({7'd0, dt_r} > lim) ? lim[TW-1:0] : dt_r;
  assign fs_e  = (full_scale == '0) ? cdgs_pkg::FS_W'(1) : full_scale;
  assign maxc  = $signed((64'(st_e) << (cdgs_pkg::VALUE_FRAC_BITS + 1)) >> 16);
  assign diff  = $signed(64'(late_r)) - $signed(64'(now_r));
  assign chg   = (diff > maxc) ? maxc : ((diff < -maxc) ? -maxc : diff);
  assign tc    = $signed(64'(late_r)) - chg;
  assign vel_ext = 64'(vel_r);

  assign div_start = cmd.start && cdgs_pkg::is_div_step(cmd.step);
  assign mul_start = cmd.start && !cdgs_pkg::is_div_step(cmd.step);

  always_comb begin
    dvd   = '0;
    dsr   = cdgs_pkg::DSR_W'(1);
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.step)
      cdgs_pkg::STEP_GAUGE: begin
        dvd = 64'(raw_r[cdgs_pkg::RAW_W-2:0]) << cdgs_pkg::VALUE_FRAC_BITS;
        dsr = cdgs_pkg::DSR_W'(fs_e);
      end
      cdgs_pkg::STEP_XQ: begin
        dvd = 64'(dt_e) << 17;
        dsr = cdgs_pkg::DSR_W'(st_e);
      end
      cdgs_pkg::STEP_OMEGA: begin
        dvd = 64'd1 << 33;
        dsr = cdgs_pkg::DSR_W'(st_e);
      end
      cdgs_pkg::STEP_DECAY: begin
        dvd = 64'd1 << 36;
        dsr = den_r;
      end
      cdgs_pkg::STEP_X2: begin
        mul_a = 64'(xq_r);
        mul_b = 32'(xq_r);
      end
      cdgs_pkg::STEP_X3: begin
        mul_a = 64'(x2_r);
        mul_b = 32'(xq_r);
      end
      cdgs_pkg::STEP_DEN1: begin
        mul_a = 64'(x2_r);
        mul_b = cdgs_pkg::C048;
      end
      cdgs_pkg::STEP_DEN2: begin
        mul_a = 64'(x3_r);
        mul_b = cdgs_pkg::C0235;
      end
      cdgs_pkg::STEP_OC: begin
        mul_a = chg;
        mul_b = 32'(omega_r);
      end
      cdgs_pkg::STEP_TEMP: begin
        mul_a = sum_r;
        mul_b = 32'(dt_e);
      end
      cdgs_pkg::STEP_OT: begin
        mul_a = temp_r;
        mul_b = 32'(omega_r);
      end
      cdgs_pkg::STEP_NV: begin
        mul_a = vel_ext - ot_r;
        mul_b = 32'(decay_r);
      end
      cdgs_pkg::STEP_OUT: begin
        mul_a = chg + temp_r;
        mul_b = 32'(decay_r);
      end
      default: begin
        dvd = '0;
      end
    endcase
  end

  cdgs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .done     (div_done),
    .quotient (quo)
  );

  cdgs_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (prod)
  );

  assign p_s  = $signed(prod);
  assign p_sh = prod >> 16;

  // final spring update
  assign out_v = tc + cdgs_pkg::sdiv_pow2(p_s, 5'd20);
  assign up    = now_r > late_r;
  assign over  = out_v > $signed(64'(now_r));

  always_comb begin
    now_nxt   = now_r;
    late_nxt  = late_r;
    vel_nxt   = vel_r;
    xq_nxt    = xq_r;
    omega_nxt = omega_r;
    x2_nxt    = x2_r;
    x3_nxt    = x3_r;
    den_nxt   = den_r;
    decay_nxt = decay_r;
    sum_nxt   = sum_r;
    temp_nxt  = temp_r;
    ot_nxt    = ot_r;
    nv_nxt    = nv_r;
    nv_f      = nv_r;
    if (cmd.snap) begin
      late_nxt = now_r;
      vel_nxt  = '0;
    end
    if (sts.done) begin
      unique case (cmd.step)
        cdgs_pkg::STEP_GAUGE: begin
          if (raw_r[cdgs_pkg::RAW_W-1] || (raw_r == '0)) begin
            now_nxt = '0;
          end else if (quo > 64'(cdgs_pkg::LEVEL_ONE)) begin
            now_nxt = cdgs_pkg::LEVEL_ONE;
          end else begin
            now_nxt = quo[LW-1:0];
          end
        end
        cdgs_pkg::STEP_XQ:    xq_nxt    = quo[24:0];
        cdgs_pkg::STEP_OMEGA: omega_nxt = quo[30:0];
        cdgs_pkg::STEP_DECAY: decay_nxt = quo[20:0];
        cdgs_pkg::STEP_X2:    x2_nxt    = p_sh[32:0];
        cdgs_pkg::STEP_X3:    x3_nxt    = p_sh[40:0];
        cdgs_pkg::STEP_DEN1:  den_nxt   = 40'd65536 + 40'(xq_r) + p_sh[39:0];
        cdgs_pkg::STEP_DEN2:  den_nxt   = den_r + p_sh[39:0];
        cdgs_pkg::STEP_OC:    sum_nxt   = vel_ext + cdgs_pkg::sdiv_pow2(p_s, 5'd16);
        cdgs_pkg::STEP_TEMP:  temp_nxt  = cdgs_pkg::sdiv_pow2(p_s, 5'd16);
        cdgs_pkg::STEP_OT:    ot_nxt    = cdgs_pkg::sdiv_pow2(p_s, 5'd16);
        cdgs_pkg::STEP_NV:    nv_nxt    = cdgs_pkg::sdiv_pow2(p_s, 5'd20);
        cdgs_pkg::STEP_OUT: begin
          if (up == over) begin
            late_nxt = now_r;
            nv_f     = '0;
          end else if (out_v < 64'sd0) begin
            late_nxt = '0;
          end else if (out_v > ONE64) begin
            late_nxt = cdgs_pkg::LEVEL_ONE;
          end else begin
            late_nxt = out_v[LW-1:0];
          end
          if (nv_f > 64'sd2147483647) begin
            vel_nxt = 32'sh7fffffff;
          end else if (nv_f < -64'sd2147483648) begin
            vel_nxt = 32'sh80000000;
          end else begin
            vel_nxt = nv_f[31:0];
          end
        end
        default: begin
          now_nxt = now_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r  <= '0;
      late_r <= '0;
      vel_r  <= '0;
    end else begin
      now_r  <= now_nxt;
      late_r <= late_nxt;
      vel_r  <= vel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      raw_r  <= in_raw;
      dt_r   <= in_dt;
    end
    if (cmd.publish) begin
      gauge_o_r <= now_r;
      lag_o_r   <= late_r;
    end
    xq_r    <= xq_nxt;
    omega_r <= omega_nxt;
    x2_r    <= x2_nxt;
    x3_r    <= x3_nxt;
    den_r   <= den_nxt;
    decay_r <= decay_nxt;
    sum_r   <= sum_nxt;
    temp_r  <= temp_nxt;
    ot_r    <= ot_nxt;
    nv_r    <= nv_nxt;
  end

  assign sts.done    = div_done | mul_done;
  assign sts.func    = func_r;
  assign sts.dt_zero = (dt_r == '0);
  assign sts.st_zero = (smooth_time == '0);

  assign gauge_value   = gauge_o_r;
  assign lagging_value = lag_o_r;

endmodule

FILE: hdl/cdgs_ctrl.sv
// ----------------------------------------------------------------------------
// cdgs_ctrl
// Controller: accepts a request, sequences the datapath steps, hands the
// result to the output register.
// ----------------------------------------------------------------------------
module cdgs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output cdgs_pkg::cmd_t    cmd,
  input  cdgs_pkg::status_t sts
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PLAN = 5'b00010,
    S_RUN  = 5'b00100,
    S_WAIT = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  cdgs_pkg::step_t       step_r, step_nxt;
  logic                  ovalid_r, ovalid_nxt;

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    cmd.load    = 1'b0;
    cmd.start   = 1'b0;
    cmd.snap    = 1'b0;
    cmd.publish = 1'b0;
    cmd.step    = step_r;
    in_tready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PLAN;
        end
      end
      S_PLAN: begin
        priority if (sts.func == cdgs_pkg::FUNC_VALUE) begin
          step_nxt  = cdgs_pkg::STEP_GAUGE;
          state_nxt = S_RUN;
        end else if (sts.dt_zero) begin
          state_nxt = S_FIN;
        end else if (sts.st_zero) begin
          cmd.snap  = 1'b1;
          state_nxt = S_FIN;
        end else begin
          step_nxt  = cdgs_pkg::STEP_XQ;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (sts.done) begin
          if (step_r == cdgs_pkg::STEP_GAUGE || step_r == cdgs_pkg::STEP_OUT) begin
            state_nxt = S_FIN;
          end else begin
            step_nxt  = cdgs_pkg::step_t'(step_r + 4'd1);
            state_nxt = S_RUN;
          end
        end
      end
      S_FIN: begin
        if (!ovalid_r || out_tready) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ovalid_nxt = cmd.publish ? 1'b1 : (out_tready ? 1'b0 : ovalid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= cdgs_pkg::STEP_GAUGE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_tvalid = ovalid_r;

endmodule

FILE: hdl/critically_damped_gauge_smoother.sv
// ----------------------------------------------------------------------------
// critically_damped_gauge_smoother
// Normalized gauge level with a critically damped trailing level.
// ----------------------------------------------------------------------------
// One request is processed at a time; a value request runs one division on the
// 64-step serial divider. A tick request runs three divisions and nine
// multiplications on the shared serial units. A zero tick or a zero smoothing
// time skips both units. A new request is taken once the previous one has left
// for the output register, which holds the result until taken. A result still
// waiting there stalls the next result, and with it the following request.
module critically_damped_gauge_smoother (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // raw_level[23:0], delta_time[47:24]
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // gauge_value[16:0], lagging_value[33:17], zero pad
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [cdgs_pkg::FS_W-1:0]    full_scale_r, full_scale_nxt;
  logic [cdgs_pkg::TIME_W-1:0]  smooth_time_r, smooth_time_nxt;
  logic                         wr_en;
  cdgs_pkg::cmd_t               cmd;
  cdgs_pkg::status_t            sts;
  logic [cdgs_pkg::LEVEL_W-1:0] gauge_value, lagging_value;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    full_scale_nxt  = full_scale_r;
    smooth_time_nxt = smooth_time_r;
    if (wr_en) begin
      if (cfg_paddr[2] == cdgs_pkg::ADDR_SMOOTH_TIME[2]) begin
        smooth_time_nxt = cfg_pwdata[cdgs_pkg::TIME_W-1:0];
      end else begin
        full_scale_nxt = cfg_pwdata[cdgs_pkg::FS_W-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == cdgs_pkg::ADDR_FULL_SCALE[2]) ?
                      32'(full_scale_r) : 32'(smooth_time_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r  <= cdgs_pkg::FS_W'(100);
      smooth_time_r <= cdgs_pkg::TIME_W'(32768);
    end else begin
      full_scale_r  <= full_scale_nxt;
      smooth_time_r <= smooth_time_nxt;
    end
  end

  cdgs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  cdgs_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_func       (in_tuser),
    .in_raw        (in_tdata[23:0]),
    .in_dt         (in_tdata[47:24]),
    .full_scale    (full_scale_r),
    .smooth_time   (smooth_time_r),
    .gauge_value   (gauge_value),
    .lagging_value (lagging_value)
  );

  assign out_tdata = {6'd0, lagging_value, gauge_value};

  // busy after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while busy");

  // a result only appears after a request was in work
  a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without request");

  // levels stay within full scale
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[16:0] <= cdgs_pkg::LEVEL_ONE &&
                    out_tdata[33:17] <= cdgs_pkg::LEVEL_ONE))
    else $error("level beyond full scale");

endmodule
